>>> rtl/uwm_pkg.sv
// Package for the unaligned word memory: action codes, register offsets,
// result record and the byte-lane merge helpers. No dependencies.
package uwm_pkg;

  localparam logic [1:0]  ACT_LOAD    = 2'd0;
  localparam logic [1:0]  ACT_STORE   = 2'd1;
  localparam logic [1:0]  ACT_INSTALL = 2'd2;

  localparam logic [7:0]  REG_SPACE_TAG = 8'hFF;
  localparam logic [23:0] REG_HALT      = 24'hFF_FFFC;
  localparam logic [23:0] REG_CONSOLE   = 24'hE0_0000;
  localparam logic [23:0] REG_FLUSH     = 24'hE0_0004;
  localparam logic [31:0] CONSOLE_EOF   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] read_data;
    logic        console_in_taken;
    logic        console_out_valid;
    logic [7:0]  console_out_byte;
    logic        flush_request;
    logic        halt_request;
  } res_t;

  // little-endian word starting at byte off of w0, spilling into w1
  function automatic logic [31:0] load_word(input logic [31:0] w0, input logic [31:0] w1,
                                            input logic [1:0] off);
    logic [63:0] pair;
    pair = {w1, w0} >> {off, 3'b000};
    return pair[31:0];
  endfunction

  function automatic logic [31:0] store_lo(input logic [31:0] old, input logic [31:0] wd,
                                           input logic [1:0] off);
    logic [63:0] sh;
    logic [63:0] msk;
    sh  = {32'h0, wd} << {off, 3'b000};
    msk = {32'h0, 32'hFFFF_FFFF} << {off, 3'b000};
    return (old & ~msk[31:0]) | sh[31:0];
  endfunction

  function automatic logic [31:0] store_hi(input logic [31:0] old, input logic [31:0] wd,
                                           input logic [1:0] off);
    logic [63:0] sh;
    logic [63:0] msk;
    sh  = {32'h0, wd} << {off, 3'b000};
    msk = {32'h0, 32'hFFFF_FFFF} << {off, 3'b000};
    return (old & ~msk[63:32]) | sh[63:32];
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [7:0] b,
                                           input logic [1:0] off);
    logic [31:0] sh;
    logic [31:0] msk;
    sh  = {24'h0, b} << {off, 3'b000};
    msk = 32'h0000_00FF << {off, 3'b000};
    return (old & ~msk) | sh;
  endfunction

endpackage

>>> rtl/uwm_ram.sv
// Word RAM: one write port, one read port, registered read data.
// Depends on nothing.
module uwm_ram #(
  parameter int WORD_ADDR_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [WORD_ADDR_BITS-1:0] rd_addr,
  output logic [31:0]               rd_data,
  input  logic                      wr_en,
  input  logic [WORD_ADDR_BITS-1:0] wr_addr,
  input  logic [31:0]               wr_data
);

  localparam int DEPTH = 1 << WORD_ADDR_BITS;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/uwm_mmio.sv
// Register-space decode: halt, console and flush registers.
// Depends on uwm_pkg.
module uwm_mmio
  import uwm_pkg::*;
(
  input  logic [1:0]  action,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic        console_in_valid,
  input  logic [7:0]  console_in_byte,
  output res_t        res
);

  logic        word_op;
  logic        in_space;
  logic [23:0] offs;

  assign word_op  = (action == ACT_LOAD) || (action == ACT_STORE);
  assign in_space = word_op && (address[31:24] == REG_SPACE_TAG);
  assign offs     = address[23:0];

  always_comb begin
    res = '0;
    if (in_space) begin
      if (offs == REG_HALT) begin
        res.halt_request = 1'b1;
      end else if (offs == REG_FLUSH) begin
        res.flush_request = 1'b1;
      end else if (offs == REG_CONSOLE) begin
        if (action == ACT_LOAD) begin
          if (console_in_valid) begin
            res.read_data        = {24'h0, console_in_byte};
            res.console_in_taken = 1'b1;
          end else begin
            res.read_data = CONSOLE_EOF;
          end
        end else begin
          res.console_out_valid = 1'b1;
          res.console_out_byte  = write_data[7:0];
        end
      end
    end
  end

endmodule

>>> rtl/unaligned_word_memory_with_mmio.sv
// Top level of the unaligned word memory with register space.
// Depends on uwm_pkg, uwm_ram and uwm_mmio.
//
// Use: drive the in_ ports and raise start; the transfer is taken at the
// edge where start is high and busy is low. Every transfer gives exactly one
// result, shown on the out_ ports for one cycle with out_strobe high. The
// receiver cannot push back, so results must be taken as they come.
// Steps from accept to strobe, set by the single RAM read port and its
// registered read data (an unaligned word spans two RAM words, read one
// after the other):
//   word load or store in RAM  read word, read next word, finish
//   byte install               read word, write back
//   register space, unmapped,
//   unused action              result at once, next transfer may follow at once
// A store writes its first word while the next word is read, then the next
// word. After reset the RAM is swept to zero, one word a cycle, through all
// 2^(RAM_ADDR_BITS-2) words with busy held high.
module unaligned_word_memory_with_mmio
  import uwm_pkg::*;
#(
  parameter int RAM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic        in_console_in_valid,
  input  logic [7:0]  in_console_in_byte,
  output logic        out_strobe,
  output logic [31:0] out_read_data,
  output logic        out_console_in_taken,
  output logic        out_console_out_valid,
  output logic [7:0]  out_console_out_byte,
  output logic        out_flush_request,
  output logic        out_halt_request
);

  localparam int WAW = RAM_ADDR_BITS - 2;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_W0    = 2'd2;   // first word on read data
  localparam logic [1:0] ST_W1    = 2'd3;   // next word on read data

  logic [1:0]     state_r, state_nxt;
  logic [WAW-1:0] clr_idx_r, clr_idx_nxt;
  logic [1:0]     act_r;
  logic [1:0]     off_r;
  logic [WAW-1:0] widx_r;
  logic [31:0]    wdata_r;
  logic [31:0]    w0_r;
  logic           strobe_r, strobe_nxt;
  res_t           res_r, res_nxt;

  logic           accept;
  logic           ram_hit;
  logic           ram_item;
  logic [WAW-1:0] widx_next;

  logic           rd_en;
  logic [WAW-1:0] rd_addr;
  logic [31:0]    rd_data;
  logic           wr_en;
  logic [WAW-1:0] wr_addr;
  logic [31:0]    wr_data;

  res_t           mmio_res;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign ram_hit  = (in_address[31:RAM_ADDR_BITS] == '0);
  // byte install ignores the high address bits and always hits the RAM
  assign ram_item = (in_action == ACT_INSTALL) ||
                    (((in_action == ACT_LOAD) || (in_action == ACT_STORE)) && ram_hit);
  assign widx_next = widx_r + 1'b1;   // wraps to word 0 at the top

  uwm_mmio u_mmio (
    .action           (in_action),
    .address          (in_address),
    .write_data       (in_write_data),
    .console_in_valid (in_console_in_valid),
    .console_in_byte  (in_console_in_byte),
    .res              (mmio_res)
  );

  uwm_ram #(
    .WORD_ADDR_BITS (WAW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // RAM port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_address[RAM_ADDR_BITS-1:2];
    wr_en   = 1'b0;
    wr_addr = widx_r;
    wr_data = '0;
    case (state_r)
      ST_IDLE: begin
        rd_en = accept && ram_item;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
      end
      ST_W0: begin
        // fetch the next word (not for an install) while the first is merged
        rd_en   = (act_r != ACT_INSTALL);
        rd_addr = widx_next;
        if (act_r == ACT_STORE) begin
          wr_en   = 1'b1;
          wr_data = store_lo(rd_data, wdata_r, off_r);
        end else if (act_r == ACT_INSTALL) begin
          wr_en   = 1'b1;
          wr_data = put_byte(rd_data, wdata_r[7:0], off_r);
        end
      end
      ST_W1: begin
        if (act_r == ACT_STORE) begin
          wr_en   = 1'b1;
          wr_addr = widx_next;
          wr_data = store_hi(rd_data, wdata_r, off_r);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // sequencer and result
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (ram_item) begin
            state_nxt = ST_W0;
          end else begin
            // register space, unmapped or unused action: done at once
            strobe_nxt = 1'b1;
            res_nxt    = mmio_res;
          end
        end
      end
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_W0: begin
        if (act_r == ACT_INSTALL) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          res_nxt    = '0;
        end else begin
          state_nxt = ST_W1;
        end
      end
      ST_W1: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        res_nxt    = '0;
        if (act_r == ACT_LOAD) begin
          res_nxt.read_data = load_word(w0_r, rd_data, off_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      act_r   <= in_action;
      off_r   <= in_address[1:0];
      widx_r  <= in_address[RAM_ADDR_BITS-1:2];
      wdata_r <= in_write_data;
    end
    if (state_r == ST_W0) begin
      w0_r <= rd_data;
    end
  end

  assign out_strobe            = strobe_r;
  assign out_read_data         = res_r.read_data;
  assign out_console_in_taken  = res_r.console_in_taken;
  assign out_console_out_valid = res_r.console_out_valid;
  assign out_console_out_byte  = res_r.console_out_byte;
  assign out_flush_request     = res_r.flush_request;
  assign out_halt_request      = res_r.halt_request;

  // a RAM word load reports after passing through ST_W0 and ST_W1, strobe registered
  a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_LOAD) && ram_hit) |-> ##3 out_strobe)
    else $error("RAM load result not on time");

  // the RAM is only written while the sequencer holds busy
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> busy)
    else $error("RAM write outside a busy period");

  // nothing is reported while the clearing sweep runs
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_strobe)
    else $error("result during RAM clear");

endmodule

>>> bench/testbench.sv
// Self-checking bench for unaligned_word_memory_with_mmio: word loads, stores,
// byte installs and register-space accesses checked against a RAM mirror.
// Depends on uwm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
  import uwm_pkg::*;

  localparam int          RAM_ADDR_BITS = 16;
  localparam int unsigned RAM_BYTES     = 1 << RAM_ADDR_BITS;
  localparam int unsigned RAM_WORDS     = 1 << (RAM_ADDR_BITS - 2);
  // action code 3 is not decoded by the block: no effect, all-zero result
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int          PHASE_ITEMS   = 510;

  // one input transfer, field for field as on the in_ ports
  typedef struct {
    logic [1:0]  act;
    logic [31:0] addr;
    logic [31:0] wd;
    logic        cv;
    logic [7:0]  cb;
  } access_t;

  // Mirror of the RAM plus the queue of results still owed by the block.
  // Accesses are applied to the mirror in the order the block takes them,
  // so each queued result already reflects every earlier store.
  class uwm_tracker;
    logic [31:0] mirror [RAM_WORDS];
    res_t        expected_results [$];
    int          errors;

    function new();
      foreach (mirror[i]) mirror[i] = '0;
      errors = 0;
    endfunction

    function void record_access(access_t a);
      res_t                     r;
      int unsigned              w0;
      int unsigned              w1;
      int unsigned              pos;
      logic [RAM_ADDR_BITS-1:0] ba;
      r = '0;
      if (a.act == ACT_INSTALL) begin
        // only the low address bits count, so any address lands in RAM
        ba = a.addr[RAM_ADDR_BITS-1:0];
        w0 = ba >> 2;
        mirror[w0][8*ba[1:0] +: 8] = a.wd[7:0];
      end else if (a.act == ACT_LOAD || a.act == ACT_STORE) begin
        if ((a.addr >> RAM_ADDR_BITS) == 0) begin
          // bytes past the addressed word go to the next one, wrapping to word 0
          w0 = (a.addr >> 2) & (RAM_WORDS - 1);
          w1 = (w0 + 1) & (RAM_WORDS - 1);
          for (int k = 0; k < 4; k++) begin
            pos = a.addr[1:0] + k;
            if (a.act == ACT_LOAD)
              r.read_data[8*k +: 8] = mirror[pos < 4 ? w0 : w1][8*(pos % 4) +: 8];
            else
              mirror[pos < 4 ? w0 : w1][8*(pos % 4) +: 8] = a.wd[8*k +: 8];
          end
        end else if (a.addr[31:24] == REG_SPACE_TAG) begin
          case (a.addr[23:0])
            REG_HALT:  r.halt_request  = 1'b1;
            REG_FLUSH: r.flush_request = 1'b1;
            REG_CONSOLE: begin
              if (a.act == ACT_LOAD) begin
                if (a.cv) begin
                  r.read_data        = {24'h0, a.cb};
                  r.console_in_taken = 1'b1;
                end else begin
                  r.read_data = CONSOLE_EOF;
                end
              end else begin
                r.console_out_valid = 1'b1;
                r.console_out_byte  = a.wd[7:0];
              end
            end
            default: ;
          endcase
        end
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string nm, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, nm, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got read_data %h",
                 $time, got.read_data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("console_in_taken", 32'(want.console_in_taken),
                    32'(got.console_in_taken));
      compare_field("console_out_valid", 32'(want.console_out_valid),
                    32'(got.console_out_valid));
      compare_field("console_out_byte", 32'(want.console_out_byte),
                    32'(got.console_out_byte));
      compare_field("flush_request", 32'(want.flush_request), 32'(got.flush_request));
      compare_field("halt_request", 32'(want.halt_request), 32'(got.halt_request));
    endfunction
  endclass

  logic        clk;
  logic        rst_n               = 1'b0;
  logic        start               = 1'b0;
  logic        busy;
  logic [1:0]  in_action           = ACT_LOAD;
  logic [31:0] in_address          = '0;
  logic [31:0] in_write_data       = '0;
  logic        in_console_in_valid = 1'b0;
  logic [7:0]  in_console_in_byte  = '0;
  logic        out_strobe;
  logic [31:0] out_read_data;
  logic        out_console_in_taken;
  logic        out_console_out_valid;
  logic [7:0]  out_console_out_byte;
  logic        out_flush_request;
  logic        out_halt_request;

  uwm_tracker tracker = new();

  unaligned_word_memory_with_mmio #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_address           (in_address),
    .in_write_data        (in_write_data),
    .in_console_in_valid  (in_console_in_valid),
    .in_console_in_byte   (in_console_in_byte),
    .out_strobe           (out_strobe),
    .out_read_data        (out_read_data),
    .out_console_in_taken (out_console_in_taken),
    .out_console_out_valid(out_console_out_valid),
    .out_console_out_byte (out_console_out_byte),
    .out_flush_request    (out_flush_request),
    .out_halt_request     (out_halt_request)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results cannot be held off: every strobe cycle is a transfer, taken at
  // the edge that ends it. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (out_strobe === 1'b1)
      tracker.check_result({out_read_data, out_console_in_taken, out_console_out_valid,
                            out_console_out_byte, out_flush_request, out_halt_request});
  end

  function automatic access_t make_access(logic [1:0] act, logic [31:0] addr,
                                          logic [31:0] wd, logic cv, logic [7:0] cb);
    access_t a;
    a.act  = act;
    a.addr = addr;
    a.wd   = wd;
    a.cv   = cv;
    a.cb   = cb;
    return a;
  endfunction

  // Mostly word traffic in two 32-byte windows (bottom of RAM and the top,
  // where the next word wraps), so loads see earlier stores and installs.
  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    logic [31:0] near;
    a.wd = $urandom;
    a.cv = 1'($urandom_range(0, 1));
    a.cb = 8'($urandom_range(0, 255));
    near = ($urandom_range(0, 1) ? 0 : RAM_BYTES - 32) + $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      a.act  = ACT_STORE;
      a.addr = near;
    end else if (pick < 55) begin
      a.act  = ACT_LOAD;
      a.addr = near;
    end else if (pick < 65) begin
      // high address bits random: the install must ignore them
      a.act  = ACT_INSTALL;
      a.addr = $urandom;
      a.addr[RAM_ADDR_BITS-1:0] = near[RAM_ADDR_BITS-1:0];
    end else if (pick < 72) begin
      a.act  = $urandom_range(0, 1) ? ACT_LOAD : ACT_STORE;
      a.addr = $urandom_range(0, RAM_BYTES - 1);
    end else if (pick < 84) begin
      a.act = $urandom_range(0, 1) ? ACT_LOAD : ACT_STORE;
      case ($urandom_range(0, 3))
        0:       a.addr = {REG_SPACE_TAG, REG_HALT};
        1:       a.addr = {REG_SPACE_TAG, REG_CONSOLE};
        2:       a.addr = {REG_SPACE_TAG, REG_FLUSH};
        default: a.addr = {REG_SPACE_TAG, 24'($urandom)};
      endcase
    end else if (pick < 96) begin
      // unmapped hole between RAM and register space
      a.act  = $urandom_range(0, 1) ? ACT_LOAD : ACT_STORE;
      a.addr = $urandom;
      if (a.addr[31:24] == REG_SPACE_TAG) a.addr[31:24] = 8'($urandom_range(0, 254));
      if ((a.addr >> RAM_ADDR_BITS) == 0) a.addr[RAM_ADDR_BITS] = 1'b1;
    end else begin
      a.act  = ACT_UNUSED;
      a.addr = $urandom;
    end
    return a;
  endfunction

  // Present one transfer and hold it until taken; then maybe idle a while.
  // start is only lowered when a gap follows, so back-to-back transfers keep
  // it high without a second assignment in the same step.
  task automatic send_access(input access_t a, input int idle_pct);
    int gap;
    start               <= 1'b1;
    in_action           <= a.act;
    in_address          <= a.addr;
    in_write_data       <= a.wd;
    in_console_in_valid <= a.cv;
    in_console_in_byte  <= a.cb;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.record_access(a);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap   = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver cannot stall, so only the sender's idling varies by phase
  int idle_plan [3] = '{0, 60, 38};

  initial begin
    int drain;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // the first transfer waits out the RAM clearing sweep through busy

    // directed: RAM extremes, unaligned spills, wrap at the top word
    send_access(make_access(ACT_STORE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_0000, 32'h0000_0000, 1'b1, 8'hFF), 0);
    send_access(make_access(ACT_STORE,   32'h0000_0101, 32'hA5C3_1E77, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_0101, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_0100, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_0104, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_STORE,   32'h0000_FFFE, 32'h1234_5678, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_FFFE, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_STORE,   32'h0000_FFFF, 32'h89AB_CDEF, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_FFFF, 32'h0000_0000, 1'b0, 8'h00), 0);
    // byte installs, high address bits ignored
    send_access(make_access(ACT_INSTALL, 32'hFFFF_0003, 32'hFFFF_FF5A, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_INSTALL, 32'h0000_FFFC, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'h0000_FFFD, 32'h0000_0000, 1'b0, 8'h00), 0);
    // register space: halt, flush, console with and without input
    send_access(make_access(ACT_LOAD,    32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_STORE,   32'hFFFF_FFFC, 32'h0000_0001, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'hFFE0_0004, 32'h0000_0000, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_STORE,   32'hFFE0_0004, 32'hFFFF_FFFF, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_LOAD,    32'hFFE0_0000, 32'h0000_0000, 1'b0, 8'hFF), 0);
    send_access(make_access(ACT_LOAD,    32'hFFE0_0000, 32'h0000_0000, 1'b1, 8'h80), 0);
    send_access(make_access(ACT_STORE,   32'hFFE0_0000, 32'hDEAD_BEC3, 1'b0, 8'h00), 0);
    // unlisted register offset, unmapped hole, unused action
    send_access(make_access(ACT_LOAD,    32'hFF00_0000, 32'h0000_0000, 1'b1, 8'h11), 0);
    send_access(make_access(ACT_STORE,   32'hFF12_3456, 32'h7777_7777, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_STORE,   32'h0001_0000, 32'hCAFE_F00D, 1'b0, 8'h00), 0);
    send_access(make_access(ACT_UNUSED,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'hFF), 0);

    foreach (idle_plan[p]) begin
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_access(random_access(), idle_plan[p]);
      if (p == 0) begin
        // hold off until the block has delivered everything owed
        start <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    drain = 0;
    while (tracker.expected_results.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (tracker.expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.expected_results.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // stop a run that hangs, well past the slowest correct run (clearing sweep included)
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
